FILE: rtl/core/bsc_pkg.sv
// Package for the barometric compensation core: register map, opcodes, helpers.
package bsc_pkg;

    localparam int RegAddrW = 6;
    localparam logic [2:0] RegIdxAc123 = 3'd0;
    localparam logic [2:0] RegIdxAc456 = 3'd1;
    localparam logic [2:0] RegIdxB1B2  = 3'd2;
    localparam logic [2:0] RegIdxMcMd  = 3'd3;
    localparam logic [2:0] RegIdxOss   = 3'd4;

    localparam logic OpTemp  = 1'b0;
    localparam logic OpPress = 1'b1;

    // Divider request and reply between the sequencer and the shared divider.
    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    function automatic logic [31:0] sext16(input logic [15:0] w);
        sext16 = {{16{w[15]}}, w};
    endfunction

    // Arithmetic right shift of a 32-bit two's complement word.
    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = $signed(x) >>> n;
    endfunction

endpackage

FILE: rtl/core/bsc_divider.sv
// Shared 32-bit radix-2 restoring divider, signed or unsigned.
module bsc_divider
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;
    logic [31:0] w_quo_out;

    assign w_rem_sh = {r_rem[30:0], r_quo[31]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_den};
    assign w_quo_out = r_neg ? (32'd0 - r_quo) : r_quo;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 32'd0;
            // take magnitudes, remember the quotient sign
            n_quo  = (i_req.is_signed && i_req.num[31]) ? (32'd0 - i_req.num) : i_req.num;
            n_den  = (i_req.is_signed && i_req.den[31]) ? (32'd0 - i_req.den) : i_req.den;
            n_neg  = i_req.is_signed && (i_req.num[31] ^ i_req.den[31]);
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_rem_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = w_quo_out;

endmodule

FILE: rtl/core/baro_sensor_compensation_core.sv
// Top level of the barometric compensation core: registers, sequencer, multiplier.
//
// One reading is taken at a time; a zero divisor skips the divide and ends the reading
// early with an error result. The time is set by a single 32x32 multiplier (one
// product per cycle, registered) and a radix-2 divider, both shared among the
// steps of a small sequencer. The result waits in an output register; the input is
// ready again in the cycle after that register has been taken. Calibration words are
// written over the APB port (byte address 8*i, 64-bit data); they must be written
// only while the core is idle, which the core itself does not enforce.
module baro_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [RegAddrW-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [18:0]         i_raw_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_result_kind,
    output logic signed [31:0]  o_value,
    output logic                o_div_error
);

    localparam logic [4:0] StIdle = 5'd0;
    localparam logic [4:0] StT1   = 5'd1;   // (ut-ac6)*ac5
    localparam logic [4:0] StT2   = 5'd2;   // start mc<<11 / den
    localparam logic [4:0] StT3   = 5'd3;   // wait divider
    localparam logic [4:0] StP1   = 5'd4;   // b6*b6
    localparam logic [4:0] StP2   = 5'd5;   // b2*sq
    localparam logic [4:0] StP3   = 5'd6;   // ac2*b6
    localparam logic [4:0] StP4   = 5'd7;   // ac3*b6
    localparam logic [4:0] StP5   = 5'd8;   // b1*sq
    localparam logic [4:0] StP6   = 5'd9;   // ac4*(x3+32768)
    localparam logic [4:0] StP7   = 5'd10;  // (up-b3)*(50000>>oss)
    localparam logic [4:0] StP8   = 5'd11;  // start divide
    localparam logic [4:0] StP9   = 5'd12;  // wait divider
    localparam logic [4:0] StP10  = 5'd13;  // (p>>8)^2
    localparam logic [4:0] StP11  = 5'd14;  // x1*3038
    localparam logic [4:0] StP12  = 5'd15;  // -7357*p
    localparam logic [4:0] StP13  = 5'd16;  // final sum
    localparam logic [4:0] StOut  = 5'd17;

    logic [47:0] r_ac123, r_ac456;
    logic [31:0] r_b1b2, r_mcmd;
    logic [1:0]  r_oss;
    logic [31:0] r_b5;

    logic [4:0]  r_state, n_state;
    logic        r_kind;
    logic [18:0] r_raw;
    logic [31:0] r_prod;
    logic [31:0] r_a, r_b, r_c, r_d;   // scratch terms
    logic        r_ovalid;
    logic [31:0] r_oval;
    logic        r_oerr;

    logic [31:0] w_ma, w_mb;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    wire w_wr = psel && penable && pwrite;
    wire [2:0] w_idx = paddr[RegAddrW-1:3];

    wire [31:0] w_ac1 = sext16(r_ac123[47:32]);
    wire [31:0] w_ac2 = sext16(r_ac123[31:16]);
    wire [31:0] w_ac3 = sext16(r_ac123[15:0]);
    wire [31:0] w_ac4 = {16'd0, r_ac456[47:32]};
    wire [31:0] w_ac5 = {16'd0, r_ac456[31:16]};
    wire [31:0] w_ac6 = {16'd0, r_ac456[15:0]};
    wire [31:0] w_b1  = sext16(r_b1b2[31:16]);
    wire [31:0] w_b2  = sext16(r_b1b2[15:0]);
    wire [31:0] w_mc  = sext16(r_mcmd[31:16]);
    wire [31:0] w_md  = sext16(r_mcmd[15:0]);
    wire [31:0] w_b6  = r_b5 - 32'd4000;
    wire [31:0] w_x1t = $signed(r_prod) >>> 15;
    wire [31:0] w_den = w_x1t + w_md;
    wire [31:0] w_pm  = 32'd50000 >> r_oss;
    // x3 of the B4 term, valid in StP6
    wire [31:0] w_x3  = asr(r_c + asr(r_prod, 5'd16) + 32'd2, 5'd2);

    // shared multiplier, operands picked by the state
    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        case (r_state)
            StT1:  begin w_ma = {16'd0, r_raw[15:0]} - w_ac6; w_mb = w_ac5; end
            StP1:  begin w_ma = w_b6;  w_mb = w_b6;  end
            StP2:  begin w_ma = w_b2;  w_mb = asr(r_prod, 5'd12); end
            StP3:  begin w_ma = w_ac2; w_mb = w_b6;  end
            StP4:  begin w_ma = w_ac3; w_mb = w_b6;  end
            StP5:  begin w_ma = w_b1;  w_mb = r_a;   end
            StP6:  begin w_ma = w_ac4; w_mb = w_x3 + 32'd32768; end
            StP7:  begin w_ma = {13'd0, r_raw} - r_b; w_mb = w_pm; end
            StP10: begin w_ma = $signed(r_d) >>> 8; w_mb = $signed(r_d) >>> 8; end
            StP11: begin w_ma = r_prod; w_mb = 32'd3038; end
            StP12: begin w_ma = 32'd0 - 32'd7357; w_mb = r_d; end
            default: ;
        endcase
    end

    wire [31:0] w_full = w_ma * w_mb;

    always_comb begin
        w_dreq.start     = 1'b0;
        w_dreq.is_signed = (r_state == StT2);
        w_dreq.num       = 32'd0;
        w_dreq.den       = 32'd0;
        case (r_state)
            StT2: begin
                w_dreq.start = (w_den != 32'd0);
                w_dreq.num   = w_mc << 11;
                w_dreq.den   = w_den;
            end
            StP8: begin
                w_dreq.start = (r_a != 32'd0);
                w_dreq.num   = r_prod[31] ? r_prod : (r_prod << 1);
                w_dreq.den   = r_a;
            end
            default: ;
        endcase
    end

    bsc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: if (i_valid && o_ready) n_state = i_opcode ? StP1 : StT1;
            StT1:   n_state = StT2;
            StT2:   n_state = (w_den == 32'd0) ? StOut : StT3;
            StT3:   if (w_drsp.done) n_state = StOut;
            StP1, StP2, StP3, StP4, StP5, StP6, StP7: n_state = r_state + 5'd1;
            StP8:   n_state = (r_a == 32'd0) ? StOut : StP9;
            StP9:   if (w_drsp.done) n_state = StP10;
            StP10, StP11, StP12: n_state = r_state + 5'd1;
            StP13:  n_state = StOut;
            StOut:  n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_ovalid <= 1'b0;
            r_ac123  <= '0;
            r_ac456  <= '0;
            r_b1b2   <= '0;
            r_mcmd   <= '0;
            r_oss    <= '0;
            r_b5     <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                case (w_idx)
                    RegIdxAc123: r_ac123 <= pwdata[47:0];
                    RegIdxAc456: r_ac456 <= pwdata[47:0];
                    RegIdxB1B2:  r_b1b2  <= pwdata[31:0];
                    RegIdxMcMd:  r_mcmd  <= pwdata[31:0];
                    RegIdxOss:   r_oss   <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == StOut) r_ovalid <= 1'b1;
            if (r_state == StT3 && w_drsp.done) r_b5 <= r_b + w_drsp.quo;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_full;
        case (r_state)
            StIdle: begin
                if (i_valid && o_ready) begin
                    r_kind <= i_opcode;
                    r_raw  <= i_raw_value;
                end
            end
            StT1: ;
            StT2: begin
                r_b    <= w_x1t;
                r_a    <= w_den;
            end
            StP2: r_a <= $signed(r_prod) >>> 12;           // sq
            StP3: r_b <= $signed(r_prod) >>> 11;           // x1
            StP4: begin                                     // b3
                r_b <= asr((((w_ac1 << 2) + r_b + asr(r_prod, 5'd11)) << r_oss) + 32'd2,
                           5'd2);
            end
            StP5: r_c <= $signed(r_prod) >>> 13;            // x1
            StP6: r_c <= w_x3;
            StP7: r_a <= r_prod >> 15;                       // b4
            StP8: r_c <= r_prod;                             // keep b7 for the shift choice
            StP9: if (w_drsp.done) r_d <= r_c[31] ? (w_drsp.quo << 1) : w_drsp.quo;
            StP12: r_c <= asr(r_prod, 5'd16);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == StT2 && w_den == 32'd0) begin
            r_oval <= 32'd0; r_oerr <= 1'b1;
        end else if (r_state == StP8 && r_a == 32'd0) begin
            r_oval <= 32'd0; r_oerr <= 1'b1;
        end else if (r_state == StT3 && w_drsp.done) begin
            r_oval <= $signed(r_b + w_drsp.quo + 32'd8) >>> 4;
            r_oerr <= 1'b0;
        end else if (r_state == StP13) begin
            r_oval <= r_d + asr(r_c + asr(r_prod, 5'd16) + 32'd3791, 5'd4);
            r_oerr <= 1'b0;
        end
    end

    always_comb begin
        prdata = 64'd0;
        case (w_idx)
            RegIdxAc123: prdata = {16'd0, r_ac123};
            RegIdxAc456: prdata = {16'd0, r_ac456};
            RegIdxB1B2:  prdata = {32'd0, r_b1b2};
            RegIdxMcMd:  prdata = {32'd0, r_mcmd};
            RegIdxOss:   prdata = {62'd0, r_oss};
            default:     prdata = 64'd0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_ready       = (r_state == StIdle) && !r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_result_kind = r_kind;
    assign o_value       = r_oval;
    assign o_div_error   = r_oerr;

endmodule

FILE: rtl/core/bsc_checker.sv
// Port-level checker for the barometric compensation core, bound to the top level.
module bsc_checker
    import bsc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_opcode,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_result_kind,
    input logic [31:0] o_value,
    input logic        o_div_error
);

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_error |-> o_value == 32'd0) else $error("error result not zero");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_result_kind))
        else $error("result changed while stalled");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("result too early");

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (.*);
